// ===== src/tcw_pkg.sv =====
// tcw_pkg: shared types and constants for the text console writer
// no dependencies; used by text_console_writer_unit
`default_nettype none

package tcw_pkg;

  // default screen geometry
  localparam int unsigned ColumnsDef = 80;
  localparam int unsigned RowsDef    = 25;

  // field widths fixed by the interface
  localparam int unsigned CmdW     = 2;
  localparam int unsigned ColInW   = 7;
  localparam int unsigned RowInW   = 5;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CellOutW = 11;

  // command codes
  localparam logic [CmdW-1:0] CMD_PUT  = 2'd0;
  localparam logic [CmdW-1:0] CMD_SET  = 2'd1;
  localparam logic [CmdW-1:0] CMD_READ = 2'd2;

  // character code that moves to the next row
  localparam logic [ByteW-1:0] NEWLINE_CODE = 8'd10;

  // attribute used after reset when a put gives attribute zero
  localparam logic [ByteW-1:0] DEFAULT_ATTR_RST = 8'd7;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_CLEAR_END,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_SCROLL_END
  } state_e;

endpackage

`default_nettype wire

// ===== src/text_console_writer_unit.sv =====
// text_console_writer_unit: text screen buffer with cursor, scroll and cell read-back
// the screen is one synchronous memory; depends on tcw_pkg
//
// put, set cursor and no-op give their word the cycle after acceptance; read cell goes through ST_READ first
// a put that scrolls walks the whole memory in ST_SCROLL and gives its word from ST_SCROLL_END
// throughput: one word per cycle for put, set cursor and no-op unless the output stalls; a read
// holds off the next command in ST_READ, bounded by the single read port and its registered read
// reset: the clearing pass writes zero to all COLUMNS*ROWS cells in ST_CLEAR and ST_CLEAR_END
// with the input stalled; the default attribute register is written meanwhile as usual
`default_nettype none

module text_console_writer_unit #(
  parameter int unsigned COLUMNS = tcw_pkg::ColumnsDef,
  parameter int unsigned ROWS    = tcw_pkg::RowsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_wr_en_i,
  input  wire logic [tcw_pkg::ByteW-1:0]    cfg_wr_data_i,
  // command channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [tcw_pkg::CmdW-1:0]     command_i,
  input  wire logic                         use_position_i,
  input  wire logic [tcw_pkg::ColInW-1:0]   column_i,
  input  wire logic [tcw_pkg::RowInW-1:0]   row_i,
  input  wire logic [tcw_pkg::ByteW-1:0]    character_i,
  input  wire logic [tcw_pkg::ByteW-1:0]    attribute_i,
  // result channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [tcw_pkg::CellOutW-1:0]      cursor_cell_o,
  output logic                              scrolled_o,
  output logic [tcw_pkg::ByteW-1:0]         read_character_o,
  output logic [tcw_pkg::ByteW-1:0]         read_attribute_o
);

  localparam int unsigned Cells = COLUMNS * ROWS;
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned RW    = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int unsigned AW    = $clog2(Cells);
  localparam int unsigned DW    = 2 * tcw_pkg::ByteW;

  localparam logic [CW-1:0] LastCol  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LastRow  = RW'(ROWS - 1);
  localparam logic [AW-1:0] LastCell = AW'(Cells - 1);
  localparam logic [AW-1:0] CopyEnd  = AW'(Cells - COLUMNS);

  // screen memory
  logic [DW-1:0] mem [Cells];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [DW-1:0] mem_wd;
  logic [AW-1:0] mem_ra;
  logic [DW-1:0] rd_q;

  // control and cursor state
  tcw_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cur_col_q, cur_col_d;
  logic [RW-1:0]   cur_row_q, cur_row_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic            wr_v_q, wr_v_d;
  logic            wr_copy_q, wr_copy_d;
  logic [AW-1:0]   wr_addr_q, wr_addr_d;
  logic [tcw_pkg::ByteW-1:0] dflt_attr_q;

  // output register
  logic                          out_valid_q, out_valid_d;
  logic                          out_load;
  logic [tcw_pkg::CellOutW-1:0]  out_cell_q, out_cell_d;
  logic                          out_scr_q, out_scr_d;
  logic [tcw_pkg::ByteW-1:0]     out_rch_q, out_rch_d;
  logic [tcw_pkg::ByteW-1:0]     out_rat_q, out_rat_d;

  // datapath helpers
  logic [CW-1:0] tgt_col, sel_col, put_col;
  logic [RW-1:0] tgt_row, sel_row, put_row;
  logic [AW-1:0] sel_addr;
  logic          put_scroll;
  logic          is_nl;
  logic [tcw_pkg::ByteW-1:0] eff_attr;
  logic          in_take;

  // clamp the given position to the screen
  assign tgt_col = (32'(column_i) > COLUMNS - 1) ? LastCol : CW'(column_i);
  assign tgt_row = (32'(row_i) > ROWS - 1) ? LastRow : RW'(row_i);

  // target cell of put and read
  assign sel_col  = use_position_i ? tgt_col : cur_col_q;
  assign sel_row  = use_position_i ? tgt_row : cur_row_q;
  assign sel_addr = AW'(32'(sel_row) * COLUMNS + 32'(sel_col));

  assign is_nl    = (character_i == tcw_pkg::NEWLINE_CODE);
  assign eff_attr = (attribute_i == '0) ? dflt_attr_q : attribute_i;

  // cursor after a put: advance one cell, or to the next row start on newline; scroll past the last row
  always_comb begin
    put_scroll = 1'b0;
    put_col    = sel_col + CW'(1);
    put_row    = sel_row;
    if (is_nl || sel_col == LastCol) begin
      put_col = '0;
      if (sel_row == LastRow) begin
        put_scroll = 1'b1;
      end else begin
        put_row = sel_row + RW'(1);
      end
    end
  end

  // input side is open only when idle with room in the output register
  assign in_stall_o = !(state_q == tcw_pkg::ST_IDLE && (!out_valid_q || !out_stall_i));
  assign in_take    = in_valid_i && !in_stall_o;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcw_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state, memory port control and result loading
  always_comb begin
    state_d   = state_q;
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    idx_d     = idx_q;
    wr_v_d    = 1'b0;
    wr_copy_d = 1'b0;
    wr_addr_d = idx_q;
    mem_we    = wr_v_q;
    mem_wa    = wr_addr_q;
    mem_wd    = wr_copy_q ? rd_q : '0;
    mem_ra    = sel_addr;
    out_load  = 1'b0;
    out_scr_d = 1'b0;
    out_rch_d = '0;
    out_rat_d = '0;

    unique case (state_q)
      tcw_pkg::ST_IDLE: begin
        if (in_take) begin
          unique case (command_i)
            tcw_pkg::CMD_PUT: begin
              if (!is_nl) begin
                mem_we = 1'b1;
                mem_wa = sel_addr;
                mem_wd = {eff_attr, character_i};
              end
              cur_col_d = put_col;
              cur_row_d = put_row;
              if (put_scroll) begin
                idx_d   = '0;
                state_d = tcw_pkg::ST_SCROLL;
              end else begin
                out_load = 1'b1;
              end
            end
            tcw_pkg::CMD_SET: begin
              cur_col_d = tgt_col;
              cur_row_d = tgt_row;
              out_load  = 1'b1;
            end
            tcw_pkg::CMD_READ: begin
              state_d = tcw_pkg::ST_READ;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      tcw_pkg::ST_READ: begin
        out_load  = 1'b1;
        out_rch_d = rd_q[tcw_pkg::ByteW-1:0];
        out_rat_d = rd_q[DW-1:tcw_pkg::ByteW];
        state_d   = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_CLEAR, tcw_pkg::ST_SCROLL: begin
        // read one row ahead, write through the registered sweep write stage
        mem_ra    = AW'(32'(idx_q) + COLUMNS);
        wr_v_d    = 1'b1;
        wr_addr_d = idx_q;
        wr_copy_d = (state_q == tcw_pkg::ST_SCROLL) && (idx_q < CopyEnd);
        idx_d     = idx_q + AW'(1);
        if (idx_q == LastCell) begin
          state_d = (state_q == tcw_pkg::ST_SCROLL) ? tcw_pkg::ST_SCROLL_END
                                                    : tcw_pkg::ST_CLEAR_END;
        end
      end
      tcw_pkg::ST_CLEAR_END: begin
        state_d = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_SCROLL_END: begin
        out_load  = 1'b1;
        out_scr_d = 1'b1;
        state_d   = tcw_pkg::ST_IDLE;
      end
      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  // cursor cell of the word, taken from the updated cursor
  assign out_cell_d  = tcw_pkg::CellOutW'(32'(cur_row_d) * COLUMNS + 32'(cur_col_d));
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      idx_q       <= '0;
      wr_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      dflt_attr_q <= tcw_pkg::DEFAULT_ATTR_RST;
    end else begin
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      idx_q       <= idx_d;
      wr_v_q      <= wr_v_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr_en_i) begin
        dflt_attr_q <= cfg_wr_data_i;
      end
    end
  end

  // sweep write pipeline payload
  always_ff @(posedge clk_i) begin
    wr_copy_q <= wr_copy_d;
    wr_addr_q <= wr_addr_d;
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cell_q <= out_cell_d;
      out_scr_q  <= out_scr_d;
      out_rch_q  <= out_rch_d;
      out_rat_q  <= out_rat_d;
    end
  end

  // screen memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  assign out_valid_o      = out_valid_q;
  assign cursor_cell_o    = out_cell_q;
  assign scrolled_o       = out_scr_q;
  assign read_character_o = out_rch_q;
  assign read_attribute_o = out_rat_q;

  // a read word always finds the output register empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tcw_pkg::ST_READ |-> !out_valid_q)
    else $error("read result would overwrite a waiting word");

  // sweep writes never collide with a put write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_v_q |-> state_q != tcw_pkg::ST_IDLE)
    else $error("sweep write pending while idle");

  // cursor stays on the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(cur_col_q) <= COLUMNS - 1) && (32'(cur_row_q) <= ROWS - 1))
    else $error("cursor off screen");

  // a scroll leaves the cursor at the start of the last row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scrolled_o |->
      cursor_cell_o == tcw_pkg::CellOutW'((ROWS - 1) * COLUMNS))
    else $error("scroll left cursor in wrong place");

endmodule

`default_nettype wire

// ===== sim/text_console_writer_unit_tb.sv =====
// text_console_writer_unit_tb: self-checking bench for the text console writer
// drives commands and default attribute writes, predicts every result word in a scoreboard
// depends on tcw_pkg and text_console_writer_unit
`timescale 1ns / 100ps

module text_console_writer_unit_tb;

  localparam int unsigned Cols       = tcw_pkg::ColumnsDef;
  localparam int unsigned Rows       = tcw_pkg::RowsDef;
  localparam int unsigned Cells      = Cols * Rows;
  // a scroll or the clearing pass holds everything while it walks all Cells cells
  localparam int unsigned QuietLimit = 5 * Cells;
  localparam int unsigned PhaseWords = 245;
  localparam logic [tcw_pkg::CmdW-1:0] CmdNoop = 2'd3;

  typedef struct packed {
    logic [tcw_pkg::CellOutW-1:0] cursor_cell;
    logic                         scrolled;
    logic [tcw_pkg::ByteW-1:0]    read_character;
    logic [tcw_pkg::ByteW-1:0]    read_attribute;
  } console_word_t;

  // screen model plus queue of result words still owed by the block
  class console_scoreboard;
    bit [2*tcw_pkg::ByteW-1:0] cells [Cells];
    int unsigned               cursor;
    bit [tcw_pkg::ByteW-1:0]   default_attr;
    console_word_t             expected_q [$];
    int unsigned               errors;

    function new();
      foreach (cells[i]) cells[i] = '0;
      cursor       = 0;
      default_attr = tcw_pkg::DEFAULT_ATTR_RST;
      errors       = 0;
    endfunction

    function int unsigned cell_of(logic [tcw_pkg::ColInW-1:0] col,
                                  logic [tcw_pkg::RowInW-1:0] row);
      int unsigned c;
      int unsigned r;
      c = (col > Cols - 1) ? Cols - 1 : col;
      r = (row > Rows - 1) ? Rows - 1 : row;
      return r * Cols + c;
    endfunction

    function void fail(string field, logic [15:0] want, logic [15:0] got);
      errors++;
      $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    // work out the word the block owes for one accepted command
    function void note_word(logic [tcw_pkg::CmdW-1:0] cmd, logic use_pos,
                            logic [tcw_pkg::ColInW-1:0] col,
                            logic [tcw_pkg::RowInW-1:0] row,
                            logic [tcw_pkg::ByteW-1:0] ch,
                            logic [tcw_pkg::ByteW-1:0] attr);
      int unsigned   pos;
      console_word_t w;
      w = '0;
      case (cmd)
        tcw_pkg::CMD_PUT: begin
          pos = use_pos ? cell_of(col, row) : cursor;
          if (pos >= Cells) pos = Cells - 1;
          if (attr == '0) attr = default_attr;
          if (ch == tcw_pkg::NEWLINE_CODE) begin
            pos = (pos / Cols) * Cols + Cols - 1;
          end else begin
            cells[pos] = {attr, ch};
          end
          pos++;
          // past the last cell: everything moves up a row, bottom row blanked
          if (pos >= Cells) begin
            for (int unsigned i = 0; i < Cells - Cols; i++) cells[i] = cells[i + Cols];
            for (int unsigned i = Cells - Cols; i < Cells; i++) cells[i] = '0;
            pos -= Cols;
            w.scrolled = 1'b1;
          end
          cursor = pos;
        end
        tcw_pkg::CMD_SET: begin
          cursor = cell_of(col, row);
        end
        tcw_pkg::CMD_READ: begin
          pos = use_pos ? cell_of(col, row) : cursor;
          if (pos >= Cells) pos = Cells - 1;
          w.read_character = cells[pos][tcw_pkg::ByteW-1:0];
          w.read_attribute = cells[pos][2*tcw_pkg::ByteW-1:tcw_pkg::ByteW];
        end
        default: ;
      endcase
      w.cursor_cell = cursor[tcw_pkg::CellOutW-1:0];
      expected_q.push_back(w);
    endfunction

    // compare one result word with the oldest one owed
    function void check_word(console_word_t got);
      console_word_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $error("result word with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      if (got.cursor_cell !== want.cursor_cell)
        fail("cursor_cell", want.cursor_cell, got.cursor_cell);
      if (got.scrolled !== want.scrolled)
        fail("scrolled", want.scrolled, got.scrolled);
      if (got.read_character !== want.read_character)
        fail("read_character", want.read_character, got.read_character);
      if (got.read_attribute !== want.read_attribute)
        fail("read_attribute", want.read_attribute, got.read_attribute);
    endfunction
  endclass

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         cfg_wr_en_i    = 1'b0;
  logic [tcw_pkg::ByteW-1:0]    cfg_wr_data_i  = '0;
  logic                         in_valid_i     = 1'b0;
  logic                         in_stall_o;
  logic [tcw_pkg::CmdW-1:0]     command_i      = '0;
  logic                         use_position_i = 1'b0;
  logic [tcw_pkg::ColInW-1:0]   column_i       = '0;
  logic [tcw_pkg::RowInW-1:0]   row_i          = '0;
  logic [tcw_pkg::ByteW-1:0]    character_i    = '0;
  logic [tcw_pkg::ByteW-1:0]    attribute_i    = '0;
  logic                         out_valid_o;
  logic                         out_stall_i    = 1'b0;
  logic [tcw_pkg::CellOutW-1:0] cursor_cell_o;
  logic                         scrolled_o;
  logic [tcw_pkg::ByteW-1:0]    read_character_o;
  logic [tcw_pkg::ByteW-1:0]    read_attribute_o;

  console_scoreboard console;
  bit                sender_idling = 1'b0;
  bit                sink_idling   = 1'b0;
  int unsigned       sink_hold     = 0;
  int unsigned       quiet_cycles  = 0;

  text_console_writer_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_wr_data_i   (cfg_wr_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .use_position_i  (use_position_i),
    .column_i        (column_i),
    .row_i           (row_i),
    .character_i     (character_i),
    .attribute_i     (attribute_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cursor_cell_o   (cursor_cell_o),
    .scrolled_o      (scrolled_o),
    .read_character_o(read_character_o),
    .read_attribute_o(read_attribute_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // result side back-pressure in random bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (sink_hold > 0) begin
        sink_hold--;
      end else if (sink_idling && $urandom_range(0, 4) == 0) begin
        sink_hold = $urandom_range(1, 7);
      end
      out_stall_i <= (sink_hold > 0);
    end
  end

  // watch both channels, score every word, and give up when nothing moves
  always @(posedge clk_i) begin
    console_word_t seen;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen = '{cursor_cell: cursor_cell_o, scrolled: scrolled_o,
                 read_character: read_character_o, read_attribute: read_attribute_o};
        console.check_word(seen);
      end
      if (in_valid_i && !in_stall_o)
        console.note_word(command_i, use_position_i, column_i, row_i, character_i,
                          attribute_i);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // present one command word and hold it until taken
  task automatic send_word(input logic [tcw_pkg::CmdW-1:0] cmd, input logic use_pos,
                           input logic [tcw_pkg::ColInW-1:0] col,
                           input logic [tcw_pkg::RowInW-1:0] row,
                           input logic [tcw_pkg::ByteW-1:0] ch,
                           input logic [tcw_pkg::ByteW-1:0] attr);
    int unsigned gap;
    bit          taken;
    if (sender_idling && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    use_position_i <= use_pos;
    column_i       <= col;
    row_i          <= row;
    character_i    <= ch;
    attribute_i    <= attr;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // mostly text written at the cursor, with jumps, reads and odd codes mixed in
  task automatic send_random_word();
    int unsigned                pick;
    logic [tcw_pkg::CmdW-1:0]   cmd;
    logic                       use_pos;
    logic [tcw_pkg::ColInW-1:0] col;
    logic [tcw_pkg::RowInW-1:0] row;
    logic [tcw_pkg::ByteW-1:0]  ch;
    logic [tcw_pkg::ByteW-1:0]  attr;
    pick    = $urandom_range(0, 99);
    use_pos = 1'($urandom_range(0, 1));
    col     = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(0, Cols - 1));
    row     = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                          : 5'($urandom_range(0, Rows - 1));
    ch      = 8'($urandom_range(0, 255));
    attr    = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    if (pick < 50) begin
      cmd     = tcw_pkg::CMD_PUT;
      use_pos = 1'b0;
      if ($urandom_range(0, 7) == 0) ch = tcw_pkg::NEWLINE_CODE;
    end else if (pick < 60) begin
      cmd = tcw_pkg::CMD_PUT;
      if ($urandom_range(0, 4) == 0) ch = tcw_pkg::NEWLINE_CODE;
    end else if (pick < 72) begin
      cmd = tcw_pkg::CMD_SET;
      // park near the bottom often so text runs into a scroll
      if ($urandom_range(0, 2) == 0) row = 5'($urandom_range(Rows - 3, 31));
    end else if (pick < 95) begin
      cmd = tcw_pkg::CMD_READ;
    end else begin
      cmd = CmdNoop;
    end
    send_word(cmd, use_pos, col, row, ch, attr);
  endtask

  task automatic write_default_attr(input logic [tcw_pkg::ByteW-1:0] value);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    console.default_attr = value;
    cfg_wr_en_i   <= 1'b0;
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (console.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [tcw_pkg::ByteW-1:0] attr_setting;
    bit                        last_phase;
    console = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // written while the clearing pass runs
    write_default_attr(8'hff);

    // directed words: corners, clamping, newlines and scrolls
    send_word(tcw_pkg::CMD_READ, 1'b1, 7'd0, 5'd0, 8'h00, 8'h00);
    send_word(tcw_pkg::CMD_PUT, 1'b0, 7'd0, 5'd0, 8'h41, 8'h00);
    send_word(tcw_pkg::CMD_PUT, 1'b0, 7'd0, 5'd0, 8'hff, 8'hff);
    send_word(tcw_pkg::CMD_PUT, 1'b1, 7'd79, 5'd0, 8'h00, 8'h80);
    send_word(tcw_pkg::CMD_READ, 1'b1, 7'd79, 5'd0, 8'h00, 8'h00);
    send_word(tcw_pkg::CMD_PUT, 1'b1, 7'h7f, 5'h1f, 8'h5a, 8'h01);
    send_word(tcw_pkg::CMD_READ, 1'b1, 7'd79, 5'd23, 8'h00, 8'h00);
    send_word(tcw_pkg::CMD_READ, 1'b1, 7'h7f, 5'h1f, 8'h00, 8'h00);
    send_word(tcw_pkg::CMD_READ, 1'b1, 7'd0, 5'd0, 8'h00, 8'h00);
    send_word(tcw_pkg::CMD_SET, 1'b0, 7'd40, 5'd10, 8'h00, 8'h00);
    send_word(tcw_pkg::CMD_PUT, 1'b0, 7'd0, 5'd0, tcw_pkg::NEWLINE_CODE, 8'h00);
    send_word(tcw_pkg::CMD_READ, 1'b0, 7'd5, 5'd5, 8'h00, 8'h00);
    send_word(tcw_pkg::CMD_SET, 1'b1, 7'h7f, 5'h1f, 8'h00, 8'h00);
    send_word(tcw_pkg::CMD_PUT, 1'b0, 7'd0, 5'd0, tcw_pkg::NEWLINE_CODE, 8'h22);
    send_word(tcw_pkg::CMD_SET, 1'b1, 7'd79, 5'd24, 8'h00, 8'h00);
    send_word(tcw_pkg::CMD_PUT, 1'b0, 7'd0, 5'd0, 8'h7e, 8'h00);
    send_word(tcw_pkg::CMD_PUT, 1'b1, 7'd5, 5'd24, tcw_pkg::NEWLINE_CODE, 8'h33);
    send_word(CmdNoop, 1'b1, 7'h7f, 5'h1f, 8'hff, 8'hff);
    send_word(tcw_pkg::CMD_SET, 1'b1, 7'd0, 5'd0, 8'h00, 8'h00);
    send_word(tcw_pkg::CMD_PUT, 1'b1, 7'd80, 5'd3, 8'h20, 8'h00);
    send_word(tcw_pkg::CMD_READ, 1'b1, 7'h7f, 5'd3, 8'h00, 8'h00);
    send_word(tcw_pkg::CMD_READ, 1'b1, 7'd0, 5'd25, 8'h00, 8'h00);
    send_word(tcw_pkg::CMD_READ, 1'b1, 7'd79, 5'd22, 8'h00, 8'h00);

    // random phases, each under its own default attribute
    for (int unsigned phase = 0; phase < 4; phase++) begin
      wait_results_drained();
      case (phase)
        0:       attr_setting = 8'h00;
        1:       attr_setting = 8'($urandom_range(1, 254));
        2:       attr_setting = 8'hff;
        default: attr_setting = tcw_pkg::DEFAULT_ATTR_RST;
      endcase
      write_default_attr(attr_setting);
      last_phase = (phase == 3);
      for (int unsigned k = 0; k < PhaseWords; k++) begin
        if (k % 40 == 0) begin
          sender_idling = !last_phase && ($urandom_range(0, 2) != 0);
          sink_idling   = !last_phase && ($urandom_range(0, 2) != 0);
        end
        send_random_word();
      end
    end

    wait_results_drained();
    repeat (16) @(posedge clk_i);
    if (console.errors == 0 && console.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
